### hw/rtl/rsst_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_pkg
// Shared constants, command codes and sequencer states of the range-sum
// segment tree.
// ----------------------------------------------------------------------------
package rsst_pkg;

  localparam int LEAVES_DEF  = 1024;
  localparam int IDX_W       = 10;
  localparam int VAL_W       = 32;
  localparam int SUM_W       = 42;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    CMD_SET   = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LEAF,
    ST_SIB,
    ST_ADD,
    ST_QLO,
    ST_QHI,
    ST_QOUT
  } state_t;

endpackage

### hw/rtl/rsst_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_ram
// Generic memory, one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module rsst_ram #(
  parameter int WIDTH = rsst_pkg::SUM_W,
  parameter int DEPTH = 2 * rsst_pkg::LEAVES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

### hw/rtl/rsst_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_front
// Input stage: accept transactions, drop out-of-range sets, clamp query
// ranges and turn leaf indices into tree node bounds for the queue.
// ----------------------------------------------------------------------------
module rsst_front #(
  parameter int LEAVES = rsst_pkg::LEAVES_DEF,
  parameter int HW     = $clog2(LEAVES) + 2,
  parameter int QW     = 1 + 2 * HW + rsst_pkg::VAL_W
) (
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_cmd,
  input  logic [rsst_pkg::IDX_W-1:0]        in_first_index,
  input  logic [rsst_pkg::IDX_W-1:0]        in_last_index,
  input  logic signed [rsst_pkg::VAL_W-1:0] in_leaf_value,
  input  logic                              clearing,
  input  logic                              q_full,
  output logic                              q_push,
  output logic [QW-1:0]                     q_data
);

  logic                       is_query;
  logic                       first_out;
  logic                       empty_rng;
  logic [rsst_pkg::IDX_W-1:0] last_c;
  logic [HW-1:0]              lo;
  logic [HW-1:0]              hi;

  assign in_stall  = q_full | clearing;
  assign is_query  = (rsst_pkg::cmd_t'(in_cmd) == rsst_pkg::CMD_QUERY);
  assign first_out = int'(in_first_index) >= LEAVES;

  always_comb begin
    if (int'(in_last_index) >= LEAVES) begin
      last_c = rsst_pkg::IDX_W'(LEAVES - 1);
    end else begin
      last_c = in_last_index;
    end
  end

  assign empty_rng = first_out | (in_first_index > last_c);

  always_comb begin
    if (is_query && empty_rng) begin
      lo = HW'(1);
      hi = HW'(1);
    end else begin
      lo = HW'(in_first_index) + HW'(LEAVES);
      hi = HW'(last_c) + HW'(LEAVES) + HW'(1);
    end
  end

  assign q_push = in_valid & ~in_stall & (is_query | ~first_out);
  assign q_data = {is_query, lo, hi, in_leaf_value};

endmodule

### hw/rtl/rsst_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_queue
// Short FIFO between the input stage and the tree sequencer.
// ----------------------------------------------------------------------------
module rsst_queue #(
  parameter int W     = 8,
  parameter int DEPTH = rsst_pkg::QUEUE_DEPTH
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         push,
  input  logic [W-1:0] push_data,
  input  logic         pop,
  output logic         full,
  output logic         q_valid,
  output logic [W-1:0] q_data
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] count_r, count_nxt;

  function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
    if (int'(p) == DEPTH - 1) begin
      return '0;
    end
    return p + PW'(1);
  endfunction

  assign full    = (int'(count_r) == DEPTH);
  assign q_valid = (count_r != '0);
  assign q_data  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r + CW'(push) - CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

### hw/rtl/rsst_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rsst_back
// Tree sequencer: clears the node memory after reset, walks a set up from the
// leaf to the root and walks a query up from both range ends, then drives
// the result register.
// ----------------------------------------------------------------------------
module rsst_back #(
  parameter int LEAVES = rsst_pkg::LEAVES_DEF,
  parameter int NW     = $clog2(LEAVES) + 1,
  parameter int HW     = NW + 1,
  parameter int QW     = 1 + 2 * HW + rsst_pkg::VAL_W
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               q_valid,
  input  logic [QW-1:0]                      q_data,
  output logic                               q_pop,
  output logic                               clearing,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rsst_pkg::SUM_W-1:0]  out_range_sum
);

  localparam int SW = rsst_pkg::SUM_W;
  localparam int VW = rsst_pkg::VAL_W;

  rsst_pkg::state_t state_r, state_nxt;

  logic [NW-1:0] pos_r, pos_nxt;
  logic [HW-1:0] lo_r, lo_nxt;
  logic [HW-1:0] hi_r, hi_nxt;
  logic [SW-1:0] cur_r, cur_nxt;
  logic          pend_r, pend_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [SW-1:0] out_sum_r, out_sum_nxt;

  logic          q_is_query;
  logic [HW-1:0] q_lo;
  logic [HW-1:0] q_hi;
  logic [VW-1:0] q_val;

  logic          ram_we;
  logic [NW-1:0] ram_waddr;
  logic [SW-1:0] ram_wdata;
  logic [NW-1:0] ram_raddr;
  logic [SW-1:0] ram_rdata;
  logic [HW-1:0] hi_dec;
  logic          out_free;

  assign {q_is_query, q_lo, q_hi, q_val} = q_data;
  assign out_free = ~out_valid_r | ~out_stall;
  assign hi_dec   = hi_r - HW'(1);

  rsst_ram #(
    .WIDTH (SW),
    .DEPTH (2 * LEAVES)
  ) u_node_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rsst_pkg::ST_CLEAR: begin
        if (pos_r == {NW{1'b1}}) begin
          state_nxt = rsst_pkg::ST_IDLE;
        end
      end
      rsst_pkg::ST_IDLE: begin
        if (q_valid) begin
          state_nxt = q_is_query ? rsst_pkg::ST_QLO : rsst_pkg::ST_LEAF;
        end
      end
      rsst_pkg::ST_LEAF: state_nxt = rsst_pkg::ST_SIB;
      rsst_pkg::ST_SIB: begin
        state_nxt = (pos_r == NW'(1)) ? rsst_pkg::ST_IDLE : rsst_pkg::ST_ADD;
      end
      rsst_pkg::ST_ADD: state_nxt = rsst_pkg::ST_SIB;
      rsst_pkg::ST_QLO: begin
        state_nxt = (lo_r >= hi_r) ? rsst_pkg::ST_QOUT : rsst_pkg::ST_QHI;
      end
      rsst_pkg::ST_QHI: state_nxt = rsst_pkg::ST_QLO;
      rsst_pkg::ST_QOUT: begin
        if (out_free) begin
          state_nxt = rsst_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsst_pkg::ST_CLEAR;
    endcase
  end

  always_comb begin
    ram_we        = 1'b0;
    ram_waddr     = pos_r;
    ram_wdata     = cur_r;
    ram_raddr     = pos_r ^ NW'(1);
    q_pop         = 1'b0;
    pos_nxt       = pos_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    cur_nxt       = pend_r ? cur_r + ram_rdata : cur_r;
    pend_nxt      = 1'b0;
    out_sum_nxt   = out_sum_r;
    out_valid_nxt = out_valid_r & out_stall;
    unique case (state_r)
      rsst_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_wdata = '0;
        pos_nxt   = pos_r + NW'(1);
      end
      rsst_pkg::ST_IDLE: begin
        if (q_valid) begin
          q_pop   = 1'b1;
          pos_nxt = q_lo[NW-1:0];
          lo_nxt  = q_lo;
          hi_nxt  = q_hi;
          cur_nxt = q_is_query ? '0 : {{(SW - VW){q_val[VW-1]}}, q_val};
        end
      end
      rsst_pkg::ST_LEAF: begin
        ram_we = 1'b1;
      end
      rsst_pkg::ST_SIB: begin
        ram_raddr = pos_r ^ NW'(1);
      end
      rsst_pkg::ST_ADD: begin
        cur_nxt   = cur_r + ram_rdata;
        ram_we    = 1'b1;
        ram_waddr = pos_r >> 1;
        ram_wdata = cur_r + ram_rdata;
        pos_nxt   = pos_r >> 1;
      end
      rsst_pkg::ST_QLO: begin
        ram_raddr = lo_r[NW-1:0];
        if (lo_r < hi_r && lo_r[0]) begin
          lo_nxt   = lo_r + HW'(1);
          pend_nxt = 1'b1;
        end
      end
      rsst_pkg::ST_QHI: begin
        ram_raddr = hi_dec[NW-1:0];
        lo_nxt    = lo_r >> 1;
        if (hi_r[0]) begin
          pend_nxt = 1'b1;
          hi_nxt   = hi_dec >> 1;
        end else begin
          hi_nxt   = hi_r >> 1;
        end
      end
      rsst_pkg::ST_QOUT: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_sum_nxt   = cur_r;
        end
      end
      default: begin
        pos_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsst_pkg::ST_CLEAR;
      pos_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      pos_r       <= pos_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    lo_r      <= lo_nxt;
    hi_r      <= hi_nxt;
    cur_r     <= cur_nxt;
    out_sum_r <= out_sum_nxt;
  end

  assign clearing      = (state_r == rsst_pkg::ST_CLEAR);
  assign out_valid     = out_valid_r;
  assign out_range_sum = $signed(out_sum_r);

endmodule

### hw/rtl/range_sum_segment_tree_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Throughput: one transaction at a time through the sequencer, bounded by the
// single read port of the node memory.
// Reset: after rst_n the node memory is cleared one node a cycle, with
// in_stall held high.
// ----------------------------------------------------------------------------
// range_sum_segment_tree_top
// Bottom-up segment tree over LEAVES leaves with point set and inclusive
// range-sum query, merged by addition modulo 2^42.
// ----------------------------------------------------------------------------
module range_sum_segment_tree_top #(
  parameter int LEAVES = rsst_pkg::LEAVES_DEF
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_cmd,
  input  logic [rsst_pkg::IDX_W-1:0]         in_first_index,
  input  logic [rsst_pkg::IDX_W-1:0]         in_last_index,
  input  logic signed [rsst_pkg::VAL_W-1:0]  in_leaf_value,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [rsst_pkg::SUM_W-1:0]  out_range_sum
);

  localparam int NW = $clog2(LEAVES) + 1;
  localparam int HW = NW + 1;
  localparam int QW = 1 + 2 * HW + rsst_pkg::VAL_W;

  logic          clearing;
  logic          q_full;
  logic          q_push;
  logic [QW-1:0] q_push_data;
  logic          q_pop;
  logic          q_valid;
  logic [QW-1:0] q_data;

  rsst_front #(
    .LEAVES (LEAVES),
    .HW     (HW),
    .QW     (QW)
  ) u_front (
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_cmd         (in_cmd),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_leaf_value  (in_leaf_value),
    .clearing       (clearing),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_push_data)
  );

  rsst_queue #(
    .W     (QW),
    .DEPTH (rsst_pkg::QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_push_data),
    .pop       (q_pop),
    .full      (q_full),
    .q_valid   (q_valid),
    .q_data    (q_data)
  );

  rsst_back #(
    .LEAVES (LEAVES),
    .NW     (NW),
    .HW     (HW),
    .QW     (QW)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_valid       (q_valid),
    .q_data        (q_data),
    .q_pop         (q_pop),
    .clearing      (clearing),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_range_sum (out_range_sum)
  );

  a_reset_stalls : assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input not stalled after reset");

  a_clear_blocks_input : assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> in_stall)
    else $error("transaction accepted during memory clear");

  a_pop_needs_entry : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  a_pop_after_clear : assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !clearing)
    else $error("queue popped during memory clear");

endmodule
